### src/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned SAT_QW     = 8;
    localparam int unsigned HUE_QW     = 5;
    localparam int unsigned HUE_NUM_W  = 13;
    localparam int unsigned DIV_STAGES = SAT_QW;
    localparam int unsigned HUE_FIRST  = SAT_QW - HUE_QW;

    // hue sector, picked by the largest channel
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam logic [7:0] HUE_WRAP       = 8'd180;
    localparam logic [7:0] HUE_GREEN_BASE = 8'd60;
    localparam logic [7:0] HUE_BLUE_BASE  = 8'd120;

    typedef struct packed {
        logic [CH_W-1:0]   mx;
        logic [CH_W-1:0]   delta;
        logic [1:0]        sector;
        logic              neg;
        logic [CH_W-1:0]   sat_num;
        logic [CH_W-1:0]   sat_rem;
        logic [SAT_QW-1:0] sat_quo;
        logic [HUE_QW-1:0] hue_num;
        logic [CH_W-1:0]   hue_rem;
        logic [HUE_QW-1:0] hue_quo;
    } div_t;

endpackage

### src/rgb_to_hsv_pixel.sv
// Converts one 8-bit blue/green/red pixel to hue (0..179, two-degree units),
// saturation and brightness (0..255). A pixel is taken on every clock where
// start is high; busy stays low, so a stream can enter at one pixel per clock.
// Each result appears on hue/saturation/brightness for one cycle with done
// high, in input order, after the capture, extremes and numerator registers,
// the 8-stage division pipeline (one saturation quotient bit per stage) that
// forms 255*delta/max and 30*diff/delta side by side, and the output register;
// the receiver must take every beat as it comes.
module rgb_to_hsv_pixel (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] blue,
    input  logic [7:0] green,
    input  logic [7:0] red,
    output logic       done,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] brightness
);
    import rgbhsv_pkg::*;

    // stage 1: capture the pixel
    logic            in_vld_reg;
    logic [CH_W-1:0] b_reg, g_reg, r_reg;

    // stage 2: extremes, sector and signed difference
    logic            ext_vld_reg;
    logic [CH_W-1:0] mx_next, mn_next, mx_reg, delta_reg;
    logic [1:0]      sector_next, sector_reg;
    logic [CH_W:0]   diff_next;
    logic            neg_reg;
    logic [CH_W-1:0] abs_next, abs_reg;

    // stage 3: numerators into the divider
    logic             num_vld_reg;
    div_t             num_next, num_reg;
    logic [15:0]      sat_full;
    logic [HUE_NUM_W-1:0] hue_full;

    // divider output and final stage
    logic             div_vld;
    div_t             div_data;
    logic [7:0]       hue_next, sat_next;
    logic [7:0]       hue_fwd;
    logic [7:0]       hue_back;
    logic             done_reg;
    logic [7:0]       hue_reg, sat_reg, bright_reg;

    assign busy = 1'b0;

    always_comb
    begin
        mx_next = r_reg;
        if (g_reg > mx_next) mx_next = g_reg;
        if (b_reg > mx_next) mx_next = b_reg;
        mn_next = r_reg;
        if (g_reg < mn_next) mn_next = g_reg;
        if (b_reg < mn_next) mn_next = b_reg;

        // ties go to red, then green
        if (mx_next == r_reg)
        begin
            sector_next = SEC_RED;
            diff_next   = {1'b0, g_reg} - {1'b0, b_reg};
        end
        else if (mx_next == g_reg)
        begin
            sector_next = SEC_GREEN;
            diff_next   = {1'b0, b_reg} - {1'b0, r_reg};
        end
        else
        begin
            sector_next = SEC_BLUE;
            diff_next   = {1'b0, r_reg} - {1'b0, g_reg};
        end
        abs_next = diff_next[CH_W] ? CH_W'(-diff_next) : diff_next[CH_W-1:0];
    end

    always_comb
    begin
        sat_full = {delta_reg, 8'd0} - {8'd0, delta_reg};
        hue_full = {abs_reg, 5'd0} - {4'd0, abs_reg, 1'b0};

        num_next         = '0;
        num_next.mx      = mx_reg;
        num_next.delta   = delta_reg;
        num_next.sector  = sector_reg;
        num_next.neg     = neg_reg;
        num_next.sat_rem = sat_full[15:8];
        num_next.sat_num = sat_full[7:0];
        num_next.hue_rem = hue_full[HUE_NUM_W-1:HUE_QW];
        num_next.hue_num = hue_full[HUE_QW-1:0];
    end

    rgbhsv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (num_vld_reg),
        .in_data  (num_reg),
        .out_vld  (div_vld),
        .out_data (div_data)
    );

    always_comb
    begin
        hue_fwd  = {3'd0, div_data.hue_quo};
        // floor of a negative quotient: step down once more on a remainder
        hue_back = hue_fwd + {7'd0, (div_data.hue_rem != '0)};
        case (div_data.sector)
            SEC_RED:
                hue_next = div_data.neg ? 8'(HUE_WRAP - hue_back) : hue_fwd;
            SEC_GREEN:
                hue_next = div_data.neg ? 8'(HUE_GREEN_BASE - hue_back)
                                        : 8'(HUE_GREEN_BASE + hue_fwd);
            SEC_BLUE:
                hue_next = div_data.neg ? 8'(HUE_BLUE_BASE - hue_back)
                                        : 8'(HUE_BLUE_BASE + hue_fwd);
            default:
                hue_next = '0;
        endcase
        if (div_data.delta == '0)
            hue_next = '0;

        sat_next = (div_data.mx == '0) ? 8'd0 : div_data.sat_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            ext_vld_reg <= 1'b0;
            num_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            ext_vld_reg <= in_vld_reg;
            num_vld_reg <= ext_vld_reg;
            done_reg    <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg      <= blue;
        g_reg      <= green;
        r_reg      <= red;
        mx_reg     <= mx_next;
        delta_reg  <= mx_next - mn_next;
        sector_reg <= sector_next;
        neg_reg    <= diff_next[CH_W];
        abs_reg    <= abs_next;
        num_reg    <= num_next;
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= div_data.mx;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 12))
        else $error("result beat without a pixel taken 12 cycles earlier");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue < HUE_WRAP)
        else $error("hue out of range");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        done && brightness == 8'd0 |-> saturation == 8'd0 && hue == 8'd0)
        else $error("black pixel gave nonzero hue or saturation");
`endif

endmodule

### src/rgbhsv_div.sv
module rgbhsv_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  rgbhsv_pkg::div_t   in_data,
    output logic               out_vld,
    output rgbhsv_pkg::div_t   out_data
);
    import rgbhsv_pkg::*;

    div_t                  stage_in   [DIV_STAGES];
    div_t                  stage_next [DIV_STAGES];
    div_t                  stage_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;

    assign stage_in[0] = in_data;
    assign vld_next    = {vld_reg[DIV_STAGES-2:0], in_vld};

    genvar k;
    generate
        for (k = 1; k < DIV_STAGES; k++)
        begin : g_link
            assign stage_in[k] = stage_reg[k-1];
        end

        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [CH_W:0]     sat_try;
            logic              sat_ge;
            logic [CH_W-1:0]   hue_rem_n;
            logic [HUE_QW-1:0] hue_quo_n;

            // one restoring step: bring down the next numerator bit, subtract if it fits
            assign sat_try = {stage_in[k].sat_rem, stage_in[k].sat_num[SAT_QW-1-k]};
            assign sat_ge  = sat_try >= {1'b0, stage_in[k].mx};

            if (k >= HUE_FIRST)
            begin : g_hue
                logic [CH_W:0] hue_try;
                logic          hue_ge;

                assign hue_try = {stage_in[k].hue_rem,
                                  stage_in[k].hue_num[HUE_QW-1-(k-HUE_FIRST)]};
                assign hue_ge  = hue_try >= {1'b0, stage_in[k].delta};
                assign hue_rem_n = hue_ge ? CH_W'(hue_try - {1'b0, stage_in[k].delta})
                                          : hue_try[CH_W-1:0];
                always_comb
                begin
                    hue_quo_n = stage_in[k].hue_quo;
                    hue_quo_n[HUE_QW-1-(k-HUE_FIRST)] = hue_ge;
                end
            end
            else
            begin : g_nohue
                assign hue_rem_n = stage_in[k].hue_rem;
                assign hue_quo_n = stage_in[k].hue_quo;
            end

            always_comb
            begin
                stage_next[k] = stage_in[k];
                stage_next[k].sat_rem = sat_ge ? CH_W'(sat_try - {1'b0, stage_in[k].mx})
                                               : sat_try[CH_W-1:0];
                stage_next[k].sat_quo[SAT_QW-1-k] = sat_ge;
                stage_next[k].hue_rem = hue_rem_n;
                stage_next[k].hue_quo = hue_quo_n;
            end

            always_ff @(posedge clk)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_data = stage_reg[DIV_STAGES-1];

endmodule
